@@ src/tcps_pkg.sv @@
// ----------------------------------------------------------------------------
// tcps_pkg
// shared constants, types and helpers for the crc protected triple store
// ----------------------------------------------------------------------------
package tcps_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam int NUM_COPIES = 3;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_INJECT = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RECOVERED = 2'd1;
  localparam logic [1:0] ST_UNRECOVERABLE = 2'd2;

  // one crc byte step, eight dependent shifts on a 32-bit word
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // double "a < b", false when either is nan
  function automatic logic dbl_lt(input logic [63:0] a, input logic [63:0] b);
    logic an, bn;
    logic lt;
    an = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
    bn = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    if (an || bn) begin
      lt = 1'b0;
    end else if ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) begin
      lt = 1'b0;
    end else if (a[63] != b[63]) begin
      lt = a[63];
    end else if (!a[63]) begin
      lt = a[62:0] < b[62:0];
    end else begin
      lt = a[62:0] > b[62:0];
    end
    return lt;
  endfunction

endpackage

@@ src/tcps_crc_unit.sv @@
// ----------------------------------------------------------------------------
// tcps_crc_unit
// byte-serial crc-32 over 8 value bytes then 4 version bytes
// ----------------------------------------------------------------------------
module tcps_crc_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] value,
  input  logic [31:0] version,
  output logic        done,
  output logic [31:0] crc
);

  logic [95:0] shift_r;
  logic [31:0] acc_r;
  logic [3:0]  cnt_r;
  logic        run_r;

  assign crc = ~acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done  <= 1'b0;
      cnt_r <= 4'd0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run_r   <= 1'b1;
        cnt_r   <= 4'd0;
        acc_r   <= tcps_pkg::CRC_INIT;
        shift_r <= {version, value};
      end else if (run_r) begin
        acc_r   <= tcps_pkg::crc_byte(acc_r, shift_r[7:0]);
        shift_r <= shift_r >> 8;
        cnt_r   <= cnt_r + 4'd1;
        if (cnt_r == 4'd11) begin
          run_r <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/tmr_crc_protected_store.sv @@
// ----------------------------------------------------------------------------
// tmr_crc_protected_store
// one double kept in three crc guarded copies with vote and scrub
// ----------------------------------------------------------------------------
// usage: pulse start with in_command and its fields while busy is low; the
// request is taken at that edge and busy stays high until the work is done.
// write: clamp negatives to +0.0, bump the version, one crc pass, then the
// result goes into all three copies; busy stays high until they are stored.
// read: three crc passes through the one shared byte-serial crc unit, a
// vote, then for ok or recovered one more crc pass for the scrub;
// out_valid pulses one cycle with out_read_value and out_read_status when
// the scrub is stored. unrecoverable reads skip the scrub and report
// straight from the vote.
// inject: flips one cell bit at the accepting edge, busy stays low, no result.
// one request at a time; the crc unit's byte loop sets the rate.
// reset: synchronous, active low; copies hold +0.0 at version 1 with its crc,
// built by a crc pass after reset (busy high meanwhile).
// results cannot be stalled: out_valid lasts exactly one cycle.
module tmr_crc_protected_store (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_new_value,
  input  logic [1:0]  in_copy_select,
  input  logic [6:0]  in_flip_position,
  output logic        out_valid,
  output logic [63:0] out_read_value,
  output logic [1:0]  out_read_status
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_CHECK, S_VOTE, S_STORE
  } state_t;

  state_t      state_r;
  logic [63:0] val_r [tcps_pkg::NUM_COPIES];
  logic [31:0] ver_r [tcps_pkg::NUM_COPIES];
  logic [31:0] chk_r [tcps_pkg::NUM_COPIES];
  logic [31:0] vcnt_r;
  logic [2:0]  good_r;
  logic [1:0]  idx_r;
  logic        go_r;
  logic        is_read_r;
  logic [63:0] st_val_r;
  logic [31:0] st_ver_r;
  logic        crc_done;
  logic [31:0] crc_out;
  logic [63:0] cu_val;
  logic [31:0] cu_ver;

  assign cu_val = (state_r == S_CHECK) ? val_r[idx_r] : st_val_r;
  assign cu_ver = (state_r == S_CHECK) ? ver_r[idx_r] : st_ver_r;

  tcps_crc_unit u_crc (
    .clk(clk), .rst_n(rst_n), .go(go_r), .value(cu_val), .version(cu_ver),
    .done(crc_done), .crc(crc_out)
  );

  assign busy = (state_r != S_IDLE);

  logic [63:0] a, b, c, t, med, lo;
  logic [1:0]  ngood;
  always_comb begin
    a = val_r[0]; b = val_r[1]; c = val_r[2];
    t = 64'd0;
    if (tcps_pkg::dbl_lt(b, a)) begin t = a; a = b; b = t; end
    if (tcps_pkg::dbl_lt(c, b)) begin t = b; b = c; c = t; end
    if (tcps_pkg::dbl_lt(b, a)) begin t = a; a = b; b = t; end
    med = b;
    lo = 64'd0;
    ngood = 2'(good_r[0]) + 2'(good_r[1]) + 2'(good_r[2]);
    priority if (good_r[0]) lo = val_r[0];
    else if (good_r[1]) lo = val_r[1];
    else lo = val_r[2];
    if (good_r[1] && tcps_pkg::dbl_lt(val_r[1], lo)) lo = val_r[1];
    if (good_r[2] && tcps_pkg::dbl_lt(val_r[2], lo)) lo = val_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      go_r      <= 1'b1;
      vcnt_r    <= 32'd1;
      st_val_r  <= 64'd0;
      st_ver_r  <= 32'd1;
      out_valid <= 1'b0;
      is_read_r <= 1'b0;
      idx_r     <= 2'd0;
      good_r    <= 3'd0;
    end else begin
      go_r      <= 1'b0;
      out_valid <= 1'b0;
      unique case (state_r)
        S_INIT, S_STORE: begin
          if (crc_done) begin
            for (int i = 0; i < tcps_pkg::NUM_COPIES; i++) begin
              val_r[i] <= st_val_r;
              ver_r[i] <= st_ver_r;
              chk_r[i] <= crc_out;
            end
            state_r <= S_IDLE;
            if (is_read_r) out_valid <= 1'b1;
          end
        end
        S_IDLE: begin
          is_read_r <= 1'b0;
          if (start) begin
            unique case (tcps_pkg::cmd_t'(in_command))
              tcps_pkg::CMD_WRITE: begin
                st_val_r <= (tcps_pkg::dbl_lt(in_new_value, 64'd0)) ? 64'd0 : in_new_value;
                st_ver_r <= vcnt_r + 32'd1;
                vcnt_r   <= vcnt_r + 32'd1;
                go_r     <= 1'b1;
                state_r  <= S_STORE;
              end
              tcps_pkg::CMD_READ: begin
                idx_r   <= 2'd0;
                go_r    <= 1'b1;
                state_r <= S_CHECK;
              end
              tcps_pkg::CMD_INJECT: begin
                if (in_copy_select != 2'd3) begin
                  priority if (!in_flip_position[6])
                    val_r[in_copy_select][in_flip_position[5:0]] <=
                      ~val_r[in_copy_select][in_flip_position[5:0]];
                  else if (!in_flip_position[5])
                    ver_r[in_copy_select][in_flip_position[4:0]] <=
                      ~ver_r[in_copy_select][in_flip_position[4:0]];
                  else
                    chk_r[in_copy_select][in_flip_position[4:0]] <=
                      ~chk_r[in_copy_select][in_flip_position[4:0]];
                end
              end
              default: ;
            endcase
          end
        end
        S_CHECK: begin
          if (crc_done) begin
            good_r[idx_r] <= (crc_out == chk_r[idx_r]);
            if (idx_r == 2'd2) begin
              state_r <= S_VOTE;
            end else begin
              idx_r <= idx_r + 2'd1;
              go_r  <= 1'b1;
            end
          end
        end
        S_VOTE: begin
          if (ngood == 2'd0) begin
            out_read_value  <= val_r[0];
            out_read_status <= tcps_pkg::ST_UNRECOVERABLE;
            out_valid       <= 1'b1;
            state_r         <= S_IDLE;
          end else begin
            out_read_value  <= (ngood == 2'd3) ? med : lo;
            out_read_status <= (ngood == 2'd3) ? tcps_pkg::ST_OK : tcps_pkg::ST_RECOVERED;
            st_val_r        <= (ngood == 2'd3) ? med : lo;
            st_ver_r        <= vcnt_r;
            is_read_r       <= 1'b1;
            go_r            <= 1'b1;
            state_r         <= S_STORE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
